### design/positional_insert_delete_list_assert.svh
// Assertion macros for the positional insert/delete list.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PIDL_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pidl assertion failed: condition");

// Consequent must hold in the same cycle as the antecedent.
`define PIDL_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidl assertion failed: implication");

`endif

### design/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Field widths, request codes and status codes of the positional list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidl_pkg;

    localparam int DEPTH_DEF = 32;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 6;

    localparam logic [REQ_W-1:0] REQ_INSERT  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_DELETE  = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_READOUT = REQ_W'(2);

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

endpackage

### design/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list: packed list with insert/delete at a position.
// Insert shifts entries from the position up one, tail first, then writes the
// value; delete shifts later entries down one. A moved entry takes a read and
// a write state; readout emits entries in order. One request at a time.
// Reset clears the entry count; entry contents stay undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pidl_pkg::REQ_W-1:0]          i_req_type,
    input  logic [pidl_pkg::POS_W-1:0]          i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pidl_pkg::ST_W-1:0]           o_status,
    output logic signed [pidl_pkg::DATA_W-1:0]  o_data,
    output logic [pidl_pkg::IDX_W-1:0]          o_index,
    output logic [pidl_pkg::CNT_W-1:0]          o_entry_count,
    output logic                                o_last
);
    import pidl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_DEL,
        S_DEL_WR,
        S_RD_ADDR,
        S_RD_OUT,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_ptr;
    logic [AW-1:0]         r_pos;
    logic [DATA_W-1:0]     r_val;
    t_status               r_res_status;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [DATA_W-1:0]     r_out_data;
    logic [IDX_W-1:0]      r_out_index;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_out_last;

    logic [DATA_W-1:0]     r_mem [DEPTH];
    logic [DATA_W-1:0]     r_rd_data;

    logic                  w_out_free;
    logic                  w_out_load;
    logic [XW-1:0]         w_cnt_x;
    logic [XW-1:0]         w_in_pos_x;
    logic                  w_ptr_match;
    logic                  w_ptr_at_end;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_W-1:0]     w_wdata;
    logic [AW-1:0]         w_raddr;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_data        = r_out_data;
    assign o_index       = r_out_index;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_out_load   = ((r_state == S_RD_OUT) || (r_state == S_EMIT)) && w_out_free;
    assign w_cnt_x      = XW'(r_count);
    assign w_in_pos_x   = XW'(i_position);
    assign w_ptr_match  = (r_ptr == r_pos);
    assign w_ptr_at_end = ((XW'(r_ptr) + XW'(1)) == w_cnt_x);

    // Memory port: shift one entry per read/write pair.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = r_rd_data;
        w_raddr = r_ptr;
        unique case (r_state)
            S_INS: begin
                w_raddr = r_ptr - AW'(1);
                w_we    = w_ptr_match;
                w_waddr = r_pos;
                w_wdata = r_val;
            end
            S_INS_WR: begin
                w_we = 1'b1;
            end
            S_DEL: begin
                w_raddr = r_ptr + AW'(1);
            end
            S_DEL_WR: begin
                w_we = 1'b1;
            end
            default: begin
                w_raddr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pos        <= AW'(i_position);
                        r_val        <= i_value;
                        r_res_status <= ST_OK;
                        priority if (i_req_type == REQ_INSERT) begin
                            priority if (r_count >= DEPTH_C) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_EMIT;
                            end else if (w_in_pos_x > w_cnt_x) begin
                                r_res_status <= ST_BADPOS;
                                r_state      <= S_EMIT;
                            end else begin
                                r_ptr   <= AW'(r_count);
                                r_state <= S_INS;
                            end
                        end else if (i_req_type == REQ_DELETE) begin
                            priority if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_EMIT;
                            end else if (w_in_pos_x >= w_cnt_x) begin
                                r_res_status <= ST_BADPOS;
                                r_state      <= S_EMIT;
                            end else begin
                                r_ptr   <= AW'(i_position);
                                r_state <= S_DEL;
                            end
                        end else if (i_req_type == REQ_READOUT) begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_EMIT;
                            end else begin
                                r_ptr   <= '0;
                                r_state <= S_RD_ADDR;
                            end
                        end else begin
                            r_res_status <= ST_BADPOS;
                            r_state      <= S_EMIT;
                        end
                    end
                end
                S_INS: begin
                    if (w_ptr_match) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_ptr   <= r_ptr - AW'(1);
                    r_state <= S_INS;
                end
                S_DEL: begin
                    if (w_ptr_at_end) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_ptr   <= r_ptr + AW'(1);
                    r_state <= S_DEL;
                end
                S_RD_ADDR: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    // Hold the read address until the output register frees up.
                    if (w_out_free) begin
                        r_out_status <= ST_OK;
                        r_out_data   <= r_rd_data;
                        r_out_index  <= IDX_W'(r_ptr);
                        r_out_count  <= CNT_W'(r_count);
                        r_out_last   <= w_ptr_at_end;
                        if (w_ptr_at_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ptr   <= r_ptr + AW'(1);
                            r_state <= S_RD_ADDR;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_status <= r_res_status;
                        r_out_data   <= '0;
                        r_out_index  <= '0;
                        r_out_count  <= CNT_W'(r_count);
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "positional_insert_delete_list_assert.svh"

    `PIDL_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C)
    `PIDL_ASSERT_IMPLY(a_count_step, i_clk, i_rst_n, $past(i_rst_n), (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)))
    `PIDL_ASSERT_IMPLY(a_write_in_shift, i_clk, i_rst_n, w_we, (r_state == S_INS) || (r_state == S_INS_WR) || (r_state == S_DEL_WR))

endmodule

### bench/list_result_checker.sv
// ----------------------------------------------------------------------------
// list_result_checker
// Watches both channels of the positional list. Tracks the list contents
// from accepted requests, queues the results each request must produce and
// compares every result transfer field by field against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [pidl_pkg::REQ_W-1:0]          i_req_type,
    input  logic [pidl_pkg::POS_W-1:0]          i_position,
    input  logic [pidl_pkg::DATA_W-1:0]         i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [pidl_pkg::ST_W-1:0]           i_status,
    input  logic [pidl_pkg::DATA_W-1:0]         i_data,
    input  logic [pidl_pkg::IDX_W-1:0]          i_index,
    input  logic [pidl_pkg::CNT_W-1:0]          i_entry_count,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    import pidl_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  data;
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   count;
        logic               last;
    } list_result_t;

    logic [DATA_W-1:0] list_words [DEPTH];
    int unsigned       list_len;
    list_result_t      due_results [$];
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic list_result_t make_result(t_status st, logic [DATA_W-1:0] word,
                                                 int unsigned idx, int unsigned len,
                                                 logic fin);
        list_result_t r;
        r.status = st;
        r.data   = word;
        r.index  = IDX_W'(idx);
        r.count  = CNT_W'(len);
        r.last   = fin;
        return r;
    endfunction

    task automatic apply_list_request(input logic [REQ_W-1:0] req,
                                      input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] word);
        int unsigned i;
        int unsigned p;
        p = pos;
        case (req)
            REQ_INSERT: begin
                if (list_len >= DEPTH) begin
                    due_results.push_back(make_result(ST_FULL, '0, 0, list_len, 1'b1));
                end else if (p > list_len) begin
                    due_results.push_back(make_result(ST_BADPOS, '0, 0, list_len, 1'b1));
                end else begin
                    // shift the tail up to open the slot
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = word;
                    list_len++;
                    due_results.push_back(make_result(ST_OK, '0, 0, list_len, 1'b1));
                end
            end
            REQ_DELETE: begin
                if (list_len == 0) begin
                    due_results.push_back(make_result(ST_EMPTY, '0, 0, list_len, 1'b1));
                end else if (p >= list_len) begin
                    due_results.push_back(make_result(ST_BADPOS, '0, 0, list_len, 1'b1));
                end else begin
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    due_results.push_back(make_result(ST_OK, '0, 0, list_len, 1'b1));
                end
            end
            REQ_READOUT: begin
                if (list_len == 0) begin
                    due_results.push_back(make_result(ST_EMPTY, '0, 0, 0, 1'b1));
                end else begin
                    for (i = 0; i < list_len; i++)
                        due_results.push_back(make_result(ST_OK, list_words[i], i, list_len,
                                                          i + 1 == list_len));
                end
            end
            default: begin
                due_results.push_back(make_result(ST_BADPOS, '0, 0, list_len, 1'b1));
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        list_result_t want;
        if (due_results.size() == 0) begin
            fail_total++;
            $display("%0t: result with none due, status %0h data %0h index %0h count %0h",
                     $time, i_status, i_data, i_index, i_entry_count);
        end else begin
            want = due_results.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(i_status));
            compare_field("data", want.data, i_data);
            compare_field("index", DATA_W'(want.index), DATA_W'(i_index));
            compare_field("entry_count", DATA_W'(want.count), DATA_W'(i_entry_count));
            compare_field("last", DATA_W'(want.last), DATA_W'(i_last));
        end
    endtask

    // Requests go in before results come out, so a same-edge result still
    // finds its entry.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_list_request(i_req_type, i_position, i_value);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        o_outstanding = due_results.size();
    end

endmodule

### bench/positional_insert_delete_list_test.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_test
// Drives insert, delete and readout requests into the positional list with
// random gaps and output stalls, and lets list_result_checker predict and
// compare every result. A directed opening covers empty, full-width and
// out-of-range cases; random rounds then grow, shrink and mix the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_delete_list_test;

    import pidl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);
    localparam int QUIET_LIMIT = 4000;
    localparam int RX_HOLD     = 300;
    localparam int ROUNDS      = 6;

    typedef enum int {ROUND_GROW, ROUND_SHRINK, ROUND_MIXED} round_kind_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [REQ_W-1:0]          in_req = REQ_INSERT;
    logic [POS_W-1:0]          in_pos = '0;
    logic signed [DATA_W-1:0]  in_value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [ST_W-1:0]           out_status;
    logic signed [DATA_W-1:0]  out_data;
    logic [IDX_W-1:0]          out_index;
    logic [CNT_W-1:0]          out_count;
    logic                      out_last;

    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;
    int          out_xfers = 0;
    int unsigned stim_len = 0;
    bit          steady = 1'b0;

    positional_insert_delete_list i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (in_req),
        .i_position     (in_pos),
        .i_value        (in_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (out_status),
        .o_data         (out_data),
        .o_index        (out_index),
        .o_entry_count  (out_count),
        .o_last         (out_last)
    );

    list_result_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (in_req),
        .i_position     (in_pos),
        .i_value        (in_value),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_status       (out_status),
        .i_data         (out_data),
        .i_index        (out_index),
        .i_entry_count  (out_count),
        .i_last         (out_last),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(15, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [DATA_W-1:0] draw_word();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Hold the request until it transfers, then track the list length.
    task automatic offer(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] word);
        in_valid <= 1'b1;
        in_req   <= req;
        in_pos   <= pos;
        in_value <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (req == REQ_INSERT && stim_len < DEPTH_DEF && pos <= stim_len)
            stim_len++;
        else if (req == REQ_DELETE && stim_len > 0 && pos < stim_len)
            stim_len--;
    endtask

    task automatic pause_sender();
        int n;
        if (!steady && $urandom_range(0, 1) == 1) begin
            n = gap_len();
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    task automatic draw_request(input round_kind_t kind, output logic [REQ_W-1:0] req,
                                output logic [POS_W-1:0] pos);
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned del_pct;
        case (kind)
            ROUND_GROW:   begin ins_pct = 75; del_pct = 10; end
            ROUND_SHRINK: begin ins_pct = 10; del_pct = 75; end
            default:      begin ins_pct = 40; del_pct = 40; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            req = REQ_INSERT;
            pos = ($urandom_range(0, 9) == 0) ? POS_W'($urandom)
                                              : POS_W'($urandom_range(0, stim_len));
        end else if (roll < ins_pct + del_pct) begin
            req = REQ_DELETE;
            pos = (stim_len == 0 || $urandom_range(0, 9) == 0)
                  ? POS_W'($urandom) : POS_W'($urandom_range(0, stim_len - 1));
        end else if (roll < ins_pct + del_pct + 10) begin
            req = REQ_READOUT;
            pos = POS_W'($urandom);
        end else begin
            // noise: any code, any position
            req = REQ_W'($urandom_range(0, 3));
            pos = POS_W'($urandom);
        end
    endtask

    always @(posedge clk) begin
        if (out_valid && out_ready)
            out_xfers <= out_xfers + 1;
    end

    // Receiver: mostly ready, short stalls, a rare long one, and two long
    // hold-offs that back the list up into its input.
    initial begin
        int holds_done;
        holds_done = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if ((holds_done == 0 && out_xfers >= 30) || (holds_done == 1 && out_xfers >= 200)) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
            end else if (steady || $urandom_range(0, 9) < 7) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("positional_insert_delete_list: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        round_kind_t      plan_kind [ROUNDS];
        int               plan_len [ROUNDS];
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        plan_kind = '{ROUND_GROW, ROUND_MIXED, ROUND_SHRINK, ROUND_MIXED,
                      ROUND_GROW, ROUND_SHRINK};
        plan_len  = '{40, 20, 40, 20, 25, 25};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, out-of-range positions, word extremes,
        // front/middle/back insert and delete, the unused request code.
        offer(REQ_READOUT, 6'd0, 32'h0);                 pause_sender();
        offer(REQ_DELETE, 6'd0, 32'h0);                  pause_sender();
        offer(REQ_DELETE, 6'd63, 32'hFFFF_FFFF);         pause_sender();
        offer(REQ_INSERT, 6'd1, 32'h5);                  pause_sender();
        offer(REQ_INSERT, 6'd63, 32'h1234_5678);         pause_sender();
        offer(REQ_INSERT, 6'd0, 32'h7FFF_FFFF);          pause_sender();
        offer(REQ_INSERT, 6'd0, 32'h8000_0000);          pause_sender();
        offer(REQ_INSERT, 6'd2, 32'hFFFF_FFFF);          pause_sender();
        offer(REQ_INSERT, 6'd1, 32'h0);                  pause_sender();
        offer(REQ_READOUT, 6'd63, 32'hFFFF_FFFF);        pause_sender();
        offer(REQ_DELETE, 6'd4, 32'h0);                  pause_sender();
        offer(REQ_DELETE, 6'd63, 32'h0);                 pause_sender();
        offer(REQ_DELETE, 6'd1, 32'h0);                  pause_sender();
        offer(REQ_DELETE, 6'd2, 32'h0);                  pause_sender();
        offer(REQ_DELETE, 6'd0, 32'h0);                  pause_sender();
        offer(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF);         pause_sender();
        offer(REQ_UNUSED, 6'd0, 32'h0);                  pause_sender();
        offer(REQ_READOUT, 6'd0, 32'h0);                 pause_sender();
        offer(REQ_DELETE, 6'd0, 32'h0);                  pause_sender();
        offer(REQ_READOUT, 6'd0, 32'h0);                 pause_sender();
        drain_results();

        for (int r = 0; r < ROUNDS; r++) begin
            steady = (r == 1);
            for (int k = 0; k < plan_len[r]; k++) begin
                draw_request(plan_kind[r], req, pos);
                offer(req, pos, draw_word());
                pause_sender();
            end
            drain_results();
        end
        steady = 1'b0;

        repeat (80) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("positional_insert_delete_list: match");
        else
            $display("positional_insert_delete_list: mismatch");
        $finish;
    end

endmodule
